// ----- rtl/sha1_pkg.sv -----
// Shared types, constants and round functions for the SHA-1 core.
package sha1_pkg;

    typedef logic [31:0] word_t;
    typedef logic [4:0][31:0] hash_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic add;
        logic init;
    } round_ctrl_t;

    localparam hash_t SHA1_IV = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                 32'hEFCDAB89, 32'h67452301};

    localparam word_t K_CH  = 32'h5A827999;
    localparam word_t K_PAR = 32'h6ED9EBA1;
    localparam word_t K_MAJ = 32'h8F1BBCDC;
    localparam word_t K_END = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE        = 8'h80;
    localparam logic [6:0] LAST_ROUND      = 7'd79;
    localparam logic [5:0] BLOCK_LAST_BYTE = 6'd63;
    localparam logic [5:0] LEN_START       = 6'd56;
    localparam logic [2:0] LAST_WORD       = 3'd4;

    function automatic word_t sha1_f(input logic [6:0] idx, input word_t b,
                                     input word_t c, input word_t d);
        word_t res;
        if (idx < 7'd20)
            res = (b & c) | (~b & d);
        else if (idx < 7'd40)
            res = b ^ c ^ d;
        else if (idx < 7'd60)
            res = (b & c) | (b & d) | (c & d);
        else
            res = b ^ c ^ d;
        return res;
    endfunction

    function automatic word_t sha1_k(input logic [6:0] idx);
        word_t res;
        if (idx < 7'd20)
            res = K_CH;
        else if (idx < 7'd40)
            res = K_PAR;
        else if (idx < 7'd60)
            res = K_MAJ;
        else
            res = K_END;
        return res;
    endfunction

endpackage

// ----- rtl/sha1_if.sv -----
// Valid/ready channel interfaces for message requests and digest words.
interface sha1_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] message_byte;
    logic       byte_present;
    logic       end_of_message;

    modport source (output valid, message_byte, byte_present, end_of_message,
                    input ready);
    modport sink (input valid, message_byte, byte_present, end_of_message,
                  output ready);
endinterface

interface sha1_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_number;
    logic        final_word;

    modport source (output valid, digest_word, word_number, final_word,
                    input ready);
    modport sink (input valid, digest_word, word_number, final_word,
                  output ready);
endinterface

// ----- rtl/sha1_sched_cell.sv -----
// One 32-bit cell of the block / message schedule chain.
module sha1_sched_cell
    import sha1_pkg::*;
(
    input  logic       clk,
    input  logic       byte_shift,
    input  logic       word_shift,
    input  logic [7:0] byte_in,
    input  word_t      word_in,
    output word_t      word
);

    word_t word_reg;
    word_t word_next;

    // Byte mode packs the block big-endian; word mode rolls the schedule.
    always_comb
    begin
        word_next = word_reg;
        if (byte_shift)
            word_next = {word_reg[23:0], byte_in};
        else if (word_shift)
            word_next = word_in;
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

// ----- rtl/sha1_round.sv -----
// Round datapath: working variables a..e and the chaining value.
module sha1_round
    import sha1_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  round_ctrl_t ctrl,
    input  logic [6:0]  round_idx,
    input  word_t       w,
    output hash_t       hash
);

    hash_t work_reg;
    hash_t work_next;
    hash_t hash_reg;
    hash_t hash_next;
    word_t temp;

    assign temp = {work_reg[0][26:0], work_reg[0][31:27]}
                + sha1_f(round_idx, work_reg[1], work_reg[2], work_reg[3])
                + work_reg[4] + sha1_k(round_idx) + w;

    always_comb
    begin
        work_next = work_reg;
        hash_next = hash_reg;
        if (ctrl.load)
            work_next = hash_reg;
        if (ctrl.step)
        begin
            work_next[0] = temp;
            work_next[1] = work_reg[0];
            work_next[2] = {work_reg[1][1:0], work_reg[1][31:2]};
            work_next[3] = work_reg[2];
            work_next[4] = work_reg[3];
        end
        if (ctrl.add)
        begin
            for (int i = 0; i < 5; i++)
                hash_next[i] = hash_reg[i] + work_reg[i];
        end
        if (ctrl.init)
            hash_next = SHA1_IV;
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hash_reg <= SHA1_IV;
        else
            hash_reg <= hash_next;
    end

    assign hash = hash_reg;

endmodule

// ----- rtl/sha1_hash_core_top.sv -----
// Bytes are taken only in ST_IDLE; every 64th byte starts a compression of 80 rounds
// through the single round unit, followed by the chaining add, and no new byte is
// taken until that compression is done.
// End of message: padding goes through the cell chain one byte per cycle, one or
// two compressions follow, then five digest words, one per cycle while not stalled.
// Reset: rst_n clears control state and loads the SHA-1 initial hash values.
module sha1_hash_core_top
    import sha1_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    sha1_in_if.sink          msg,
    sha1_out_if.source       digest
);

    state_t      state_reg, state_next;
    logic [5:0]  pos_reg, pos_next;
    logic [6:0]  round_reg, round_next;
    logic [60:0] count_reg, count_next;
    logic [63:0] len_reg, len_next;
    logic        pad_reg, pad_next;
    logic        first_reg, first_next;
    logic        len_block_reg, len_block_next;
    logic [2:0]  widx_reg, widx_next;

    round_ctrl_t rctl;
    logic        byte_shift;
    logic        word_shift;
    logic [7:0]  shift_byte;
    word_t       cells [16];
    word_t       new_word;
    word_t       mix;
    hash_t       hash;

    assign mix      = cells[13] ^ cells[8] ^ cells[2] ^ cells[0];
    assign new_word = {mix[30:0], mix[31]};

    for (genvar i = 0; i < 16; i++)
    begin : g_cell
        if (i == 15)
        begin : g_tail
            sha1_sched_cell u_cell (
                .clk        (clk),
                .byte_shift (byte_shift),
                .word_shift (word_shift),
                .byte_in    (shift_byte),
                .word_in    (new_word),
                .word       (cells[i])
            );
        end
        else
        begin : g_body
            sha1_sched_cell u_cell (
                .clk        (clk),
                .byte_shift (byte_shift),
                .word_shift (word_shift),
                .byte_in    (cells[i+1][31:24]),
                .word_in    (cells[i+1]),
                .word       (cells[i])
            );
        end
    end

    sha1_round u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (rctl),
        .round_idx (round_reg),
        .w         (cells[0]),
        .hash      (hash)
    );

    assign digest.digest_word = hash[widx_reg];
    assign digest.word_number = widx_reg;
    assign digest.final_word  = (widx_reg == LAST_WORD);

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        round_next     = round_reg;
        count_next     = count_reg;
        len_next       = len_reg;
        pad_next       = pad_reg;
        first_next     = first_reg;
        len_block_next = len_block_reg;
        widx_next      = widx_reg;
        rctl           = '0;
        byte_shift     = 1'b0;
        word_shift     = 1'b0;
        shift_byte     = msg.message_byte;
        msg.ready      = 1'b0;
        digest.valid   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                msg.ready = 1'b1;
                if (msg.valid)
                begin
                    if (msg.byte_present)
                    begin
                        byte_shift = 1'b1;
                        pos_next   = pos_reg + 6'd1;
                        count_next = count_reg + 61'd1;
                    end
                    if (msg.end_of_message)
                    begin
                        pad_next   = 1'b1;
                        first_next = 1'b1;
                        len_next   = {count_reg + 61'(msg.byte_present), 3'b000};
                    end
                    if (msg.byte_present && pos_reg == BLOCK_LAST_BYTE)
                    begin
                        rctl.load  = 1'b1;
                        round_next = '0;
                        state_next = ST_ROUND;
                    end
                    else if (msg.end_of_message)
                        state_next = ST_PAD;
                end
            end
            ST_ROUND:
            begin
                rctl.step  = 1'b1;
                word_shift = 1'b1;
                round_next = round_reg + 7'd1;
                if (round_reg == LAST_ROUND)
                    state_next = ST_ADD;
            end
            ST_ADD:
            begin
                rctl.add = 1'b1;
                if (!pad_reg)
                    state_next = ST_IDLE;
                else if (len_block_reg)
                begin
                    widx_next  = '0;
                    state_next = ST_OUT;
                end
                else
                begin
                    // No room was left for the length in this block: one more block.
                    len_block_next = 1'b1;
                    state_next     = ST_PAD;
                end
            end
            ST_PAD:
            begin
                byte_shift = 1'b1;
                pos_next   = pos_reg + 6'd1;
                if (first_reg)
                begin
                    shift_byte     = PAD_BYTE;
                    first_next     = 1'b0;
                    len_block_next = (pos_reg < LEN_START);
                end
                else if (len_block_reg && pos_reg >= LEN_START)
                begin
                    shift_byte = len_reg[63:56];
                    len_next   = {len_reg[55:0], 8'h00};
                end
                else
                    shift_byte = 8'h00;
                if (pos_reg == BLOCK_LAST_BYTE)
                begin
                    rctl.load  = 1'b1;
                    round_next = '0;
                    state_next = ST_ROUND;
                end
            end
            ST_OUT:
            begin
                digest.valid = 1'b1;
                if (digest.ready)
                begin
                    if (widx_reg == LAST_WORD)
                    begin
                        rctl.init      = 1'b1;
                        pad_next       = 1'b0;
                        len_block_next = 1'b0;
                        count_next     = '0;
                        state_next     = ST_IDLE;
                    end
                    else
                        widx_next = widx_reg + 3'd1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            round_reg     <= '0;
            count_reg     <= '0;
            pad_reg       <= 1'b0;
            first_reg     <= 1'b0;
            len_block_reg <= 1'b0;
            widx_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            round_reg     <= round_next;
            count_reg     <= count_next;
            pad_reg       <= pad_next;
            first_reg     <= first_next;
            len_block_reg <= len_block_next;
            widx_reg      <= widx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg <= len_next;
    end

endmodule

// ----- rtl/sha1_checker.sv -----
// Port-level assertions for the SHA-1 core, bound to the top level.
module sha1_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] word_number,
    input logic       final_word
);

    // No new request is taken while a digest is being delivered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(in_valid && in_ready))
        else $error("request accepted during digest output");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (final_word == (word_number == 3'd4)))
        else $error("final_word does not match word 4");

    // Digest words come out back to back in order.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !final_word)
            |=> (out_valid && word_number == $past(word_number) + 3'd1))
        else $error("digest word sequence broken");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && final_word) |=> !out_valid)
        else $error("output after the last digest word");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(word_number)))
        else $error("stalled digest word changed");

endmodule

bind sha1_hash_core_top sha1_checker u_sha1_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (msg.valid),
    .in_ready    (msg.ready),
    .out_valid   (digest.valid),
    .out_ready   (digest.ready),
    .word_number (digest.word_number),
    .final_word  (digest.final_word)
);
